// ===== rtl/ipft_pkg.sv =====
package ipft_pkg;

  localparam int ENTRIES     = 1024;
  localparam int BUCKETS     = 256;
  localparam int HEADER_BITS = 64;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int BKT_W = $clog2(BUCKETS);
  localparam int LIM_W = (IDX_W + 1 > 11) ? IDX_W + 1 : 11;

  typedef logic [IDX_W:0] ptr_t;
  localparam ptr_t NIL = ptr_t'(ENTRIES);

  localparam logic [31:0] GOLDEN = 32'h9e37_79b9;

  // register indexes of the configuration port
  localparam logic [7:0] CFG_ENTRY_TIMEOUT     = 8'd0;
  localparam logic [7:0] CFG_PRUNE_PERIOD      = 8'd1;
  localparam logic [7:0] CFG_PRUNE_GRACE       = 8'd2;
  localparam logic [7:0] CFG_EMERGENCY_PERIOD  = 8'd3;
  localparam logic [7:0] CFG_ENTRY_LIMIT       = 8'd4;
  localparam logic [7:0] CFG_HASH_SEED         = 8'd5;
  localparam logic [7:0] CFG_EXTERNAL_SAMPLING = 8'd6;

  localparam logic [15:0] RST_ENTRY_TIMEOUT    = 16'd60;
  localparam logic [15:0] RST_PRUNE_PERIOD     = 16'd5;
  localparam logic [15:0] RST_PRUNE_GRACE      = 16'd0;
  localparam logic [15:0] RST_EMERGENCY_PERIOD = 16'd60;
  localparam logic [10:0] RST_ENTRY_LIMIT      = 11'd1024;
  localparam logic [31:0] RST_HASH_SEED        = 32'd140281;

  typedef struct packed {
    logic [15:0] entry_timeout;
    logic [15:0] prune_period;
    logic [15:0] prune_grace;
    logic [15:0] emergency_period;
    logic [10:0] entry_limit;
    logic [31:0] hash_seed;
    logic        external_sampling;
  } cfg_t;

  typedef struct packed {
    logic [31:0]            now_seconds;
    logic [15:0]            frag_id;
    logic [31:0]            source_address;
    logic [31:0]            dest_address;
    logic [7:0]             protocol;
    logic                   is_first;
    logic [15:0]            packet_length;
    logic [HEADER_BITS-1:0] header;
    logic [BKT_W-1:0]       bucket;
  } item_t;

  typedef struct packed {
    logic [15:0]            frag_id;
    logic [7:0]             protocol;
    logic [31:0]            src;
    logic [31:0]            dst;
    logic [31:0]            deadline;
    logic                   has_first;
    logic [31:0]            packets;
    logic [31:0]            bytes;
    logic [HEADER_BITS-1:0] header;
    logic [BKT_W-1:0]       bucket;
  } rec_t;

  function automatic logic [4:0] mix_shift(input logic [3:0] row);
    logic [4:0] s;
    unique case (row)
      4'd0:    s = 5'd13;
      4'd1:    s = 5'd8;
      4'd2:    s = 5'd13;
      4'd3:    s = 5'd12;
      4'd4:    s = 5'd16;
      4'd5:    s = 5'd5;
      4'd6:    s = 5'd3;
      4'd7:    s = 5'd10;
      4'd8:    s = 5'd15;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/ipft_if.sv =====
interface frag_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_seconds;
  logic [15:0] frag_id;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [7:0]  protocol;
  logic        is_first;
  logic [15:0] packet_length;
  logic [63:0] transport_header_in;

  modport source (output valid, now_seconds, frag_id, source_address, dest_address, protocol,
                  is_first, packet_length, transport_header_in, input ready);
  modport sink (input valid, now_seconds, frag_id, source_address, dest_address, protocol,
                is_first, packet_length, transport_header_in, output ready);
endinterface

interface frag_out_if;
  logic        valid;
  logic        ready;
  logic        header_found;
  logic [63:0] transport_header_out;
  logic        sums_valid;
  logic [31:0] sum_bytes;
  logic [31:0] sum_packets;
  logic        table_full;

  modport source (output valid, header_found, transport_header_out, sums_valid, sum_bytes,
                  sum_packets, table_full, input ready);
  modport sink (input valid, header_found, transport_header_out, sums_valid, sum_bytes,
                sum_packets, table_full, output ready);
endinterface

interface cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ipft_front.sv =====
module ipft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  frag_in_if.sink           in_i,
  input  logic [31:0]       seed_i,
  output ipft_pkg::item_t   item_o,
  output logic              item_valid_o,
  input  logic              item_ready_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MIX  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [3:0]  row_q, row_d;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] a_q, a_d, b_q, b_d, c_q, c_d;
  ipft_pkg::item_t item_q, item_d;
  logic [4:0]  sh;

  assign in_i.ready   = (state_q == F_IDLE);
  assign item_valid_o = (state_q == F_PUSH);

  always_comb begin
    item_o        = item_q;
    item_o.bucket = c_q[ipft_pkg::BKT_W-1:0];
  end

  assign sh = ipft_pkg::mix_shift(row_q);

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    phase_d = phase_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    item_d  = item_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_i.valid) begin
          item_d.now_seconds    = in_i.now_seconds;
          item_d.frag_id        = in_i.frag_id;
          item_d.source_address = in_i.source_address;
          item_d.dest_address   = in_i.dest_address;
          item_d.protocol       = in_i.protocol;
          item_d.is_first       = in_i.is_first;
          item_d.packet_length  = in_i.packet_length;
          item_d.header         = in_i.transport_header_in[ipft_pkg::HEADER_BITS-1:0];
          item_d.bucket         = '0;
          a_d     = {in_i.frag_id, 8'd0, in_i.protocol} + ipft_pkg::GOLDEN;
          b_d     = in_i.source_address + ipft_pkg::GOLDEN;
          c_d     = in_i.dest_address + seed_i;
          row_d   = 4'd0;
          phase_d = 2'd0;
          state_d = F_MIX;
        end
      end
      F_MIX: begin
        // one row of the mix per cycle
        unique case (phase_q)
          2'd0:    a_d = (a_q - b_q - c_q) ^ (c_q >> sh);
          2'd1:    b_d = (b_q - c_q - a_q) ^ (a_q << sh);
          default: c_d = (c_q - a_q - b_q) ^ (b_q >> sh);
        endcase
        phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
        row_d   = row_q + 4'd1;
        if (row_q == 4'd8) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (item_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      row_q   <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    item_q <= item_d;
  end

endmodule

// ===== rtl/ipft_fifo.sv =====
module ipft_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ipft_pkg::item_t push_item_i,
  output logic            full_o,
  output logic            valid_o,
  output ipft_pkg::item_t item_o,
  input  logic            pop_i
);

  ipft_pkg::item_t slot_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wp_q] <= push_item_i;
  end

endmodule

// ===== rtl/ipft_back.sv =====
module ipft_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ipft_pkg::cfg_t  cfg_i,
  input  logic            item_valid_i,
  input  ipft_pkg::item_t item_i,
  output logic            item_pop_o,
  frag_out_if.source      out_o
);

  localparam int IW = ipft_pkg::IDX_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PR_CHK = 4'd1;
  localparam logic [3:0] S_PR_EV  = 4'd2;
  localparam logic [3:0] S_LK_HD  = 4'd3;
  localparam logic [3:0] S_LK_HW  = 4'd4;
  localparam logic [3:0] S_LK_RD  = 4'd5;
  localparam logic [3:0] S_LK_EV  = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_RU_RD  = 4'd8;
  localparam logic [3:0] S_RU_EV  = 4'd9;
  localparam logic [3:0] S_RU_A   = 4'd10;
  localparam logic [3:0] S_RU_B   = 4'd11;
  localparam logic [3:0] S_AL_A   = 4'd12;
  localparam logic [3:0] S_AL_B   = 4'd13;
  localparam logic [3:0] S_WRITE  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  typedef struct packed {
    logic        hf;
    logic [63:0] hdr;
    logic        sv;
    logic [31:0] sb;
    logic [31:0] sp;
    logic        tf;
  } res_t;

  // entry store and link lists
  ipft_pkg::rec_t dm_mem [ipft_pkg::ENTRIES];
  ipft_pkg::ptr_t cn_mem [ipft_pkg::ENTRIES];
  ipft_pkg::ptr_t cp_mem [ipft_pkg::ENTRIES];
  ipft_pkg::ptr_t an_mem [ipft_pkg::ENTRIES];
  ipft_pkg::ptr_t ap_mem [ipft_pkg::ENTRIES];
  logic [IW-1:0]  fs_mem [ipft_pkg::ENTRIES];
  ipft_pkg::ptr_t bh_mem [ipft_pkg::BUCKETS];
  logic [ipft_pkg::BUCKETS-1:0] bh_vld_q;

  ipft_pkg::rec_t dm_rd_q;
  ipft_pkg::ptr_t cn_rd_q, cp_rd_q, an_rd_q, ap_rd_q, bh_rd_q;
  logic           bh_vld_rd_q;
  logic [IW-1:0]  fs_rd_q;

  logic           dm_we, cn_we, cp_we, an_we, ap_we, fs_we, bh_we;
  ipft_pkg::ptr_t dm_wa, cn_wa, cp_wa, an_wa, ap_wa, fs_wa;
  logic [ipft_pkg::BKT_W-1:0] bh_wa;
  ipft_pkg::rec_t dm_wd;
  ipft_pkg::ptr_t cn_wd, cp_wd, an_wd, ap_wd, bh_wd;
  logic [IW-1:0]  fs_wd;
  ipft_pkg::ptr_t rd_idx, fs_ra;

  logic [3:0]      state_q, state_d, ret_q, ret_d;
  ipft_pkg::item_t item_q, item_d;
  ipft_pkg::ptr_t  cur_q, cur_d, cand_q, cand_d, last_q, last_d, ent_q, ent_d;
  ipft_pkg::ptr_t  head_q, head_d, tail_q, tail_d;
  ipft_pkg::ptr_t  used_q, used_d, fresh_q, fresh_d, sp_q, sp_d;
  logic [32:0]     nprune_q, nprune_d;
  logic [31:0]     lastem_q, lastem_d;
  logic [15:0]     grace_q, grace_d;
  res_t            res_q, res_d, out_q, out_d;
  logic            ov_q, ov_d;

  logic                       match;
  logic [32:0]                dl_sum;
  logic [ipft_pkg::LIM_W-1:0] limit;
  ipft_pkg::rec_t             rec;

  assign out_o.valid                = ov_q;
  assign out_o.header_found         = out_q.hf;
  assign out_o.transport_header_out = out_q.hdr;
  assign out_o.sums_valid           = out_q.sv;
  assign out_o.sum_bytes            = out_q.sb;
  assign out_o.sum_packets          = out_q.sp;
  assign out_o.table_full           = out_q.tf;

  assign match = (dm_rd_q.frag_id == item_q.frag_id) && (dm_rd_q.protocol == item_q.protocol)
              && (dm_rd_q.src == item_q.source_address) && (dm_rd_q.dst == item_q.dest_address);
  assign dl_sum = {1'b0, item_q.now_seconds} + {17'd0, cfg_i.entry_timeout};
  assign limit  = (ipft_pkg::LIM_W'(cfg_i.entry_limit) > ipft_pkg::LIM_W'(ipft_pkg::ENTRIES))
                ? ipft_pkg::LIM_W'(ipft_pkg::ENTRIES) : ipft_pkg::LIM_W'(cfg_i.entry_limit);
  assign fs_ra  = sp_q - ipft_pkg::ptr_t'(1);

  always_comb begin
    unique case (state_q)
      S_PR_CHK: rd_idx = head_q;
      S_RU_RD:  rd_idx = cand_q;
      default:  rd_idx = cur_q;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    item_d   = item_q;
    cur_d    = cur_q;
    cand_d   = cand_q;
    last_d   = last_q;
    ent_d    = ent_q;
    head_d   = head_q;
    tail_d   = tail_q;
    used_d   = used_q;
    fresh_d  = fresh_q;
    sp_d     = sp_q;
    nprune_d = nprune_q;
    lastem_d = lastem_q;
    grace_d  = grace_q;
    res_d    = res_q;
    out_d    = out_q;
    ov_d     = ov_q;
    item_pop_o = 1'b0;
    rec = dm_rd_q;
    dm_we = 1'b0; dm_wa = ent_q; dm_wd = dm_rd_q;
    cn_we = 1'b0; cn_wa = ent_q; cn_wd = ipft_pkg::NIL;
    cp_we = 1'b0; cp_wa = ent_q; cp_wd = ipft_pkg::NIL;
    an_we = 1'b0; an_wa = ent_q; an_wd = ipft_pkg::NIL;
    ap_we = 1'b0; ap_wa = ent_q; ap_wd = ipft_pkg::NIL;
    fs_we = 1'b0; fs_wa = sp_q;  fs_wd = head_q[IW-1:0];
    bh_we = 1'b0; bh_wa = item_q.bucket; bh_wd = ipft_pkg::NIL;

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d = item_i;
          cand_d = ipft_pkg::NIL;
          last_d = ipft_pkg::NIL;
          res_d  = '0;
          if ({1'b0, item_i.now_seconds} > nprune_q) begin
            grace_d  = cfg_i.prune_grace;
            ret_d    = S_LK_HD;
            nprune_d = {1'b0, item_i.now_seconds} + {17'd0, cfg_i.prune_period};
            state_d  = S_PR_CHK;
          end else begin
            state_d = S_LK_HD;
          end
        end
      end
      S_PR_CHK: begin
        state_d = (head_q == ipft_pkg::NIL) ? ret_q : S_PR_EV;
      end
      S_PR_EV: begin
        if ({1'b0, item_q.now_seconds} > {1'b0, dm_rd_q.deadline} + {17'd0, grace_q}) begin
          // drop the oldest entry from its chain and the age list
          if (cp_rd_q != ipft_pkg::NIL) begin
            cn_we = 1'b1; cn_wa = cp_rd_q; cn_wd = cn_rd_q;
          end else begin
            bh_we = 1'b1; bh_wa = dm_rd_q.bucket; bh_wd = cn_rd_q;
          end
          if (cn_rd_q != ipft_pkg::NIL) begin
            cp_we = 1'b1; cp_wa = cn_rd_q; cp_wd = cp_rd_q;
          end
          head_d = an_rd_q;
          if (an_rd_q != ipft_pkg::NIL) begin
            ap_we = 1'b1; ap_wa = an_rd_q; ap_wd = ipft_pkg::NIL;
          end else begin
            tail_d = ipft_pkg::NIL;
          end
          fs_we = 1'b1;
          sp_d  = sp_q + ipft_pkg::ptr_t'(1);
          if (used_q != '0) used_d = used_q - ipft_pkg::ptr_t'(1);
          state_d = S_PR_CHK;
        end else begin
          state_d = ret_q;
        end
      end
      S_LK_HD: state_d = S_LK_HW;
      S_LK_HW: begin
        cur_d   = bh_vld_rd_q ? bh_rd_q : ipft_pkg::NIL;
        state_d = S_LK_RD;
      end
      S_LK_RD: begin
        state_d = (cur_q == ipft_pkg::NIL) ? S_DECIDE : S_LK_EV;
      end
      S_LK_EV: begin
        if (match) begin
          if (dm_rd_q.deadline > item_q.now_seconds) begin
            if (dm_rd_q.has_first) begin
              res_d.hf  = 1'b1;
              res_d.hdr = 64'(dm_rd_q.header);
            end else if (item_q.is_first) begin
              rec.has_first = 1'b1;
              rec.header    = item_q.header;
              rec.bytes     = '0;
              rec.packets   = '0;
              dm_we = 1'b1; dm_wa = cur_q; dm_wd = rec;
              res_d.hf  = 1'b1;
              res_d.hdr = 64'(item_q.header);
              res_d.sv  = 1'b1;
              res_d.sb  = dm_rd_q.bytes;
              res_d.sp  = dm_rd_q.packets;
            end else if (!cfg_i.external_sampling) begin
              rec.packets = dm_rd_q.packets + 32'd1;
              rec.bytes   = dm_rd_q.bytes + {16'd0, item_q.packet_length};
              dm_we = 1'b1; dm_wa = cur_q; dm_wd = rec;
            end
            state_d = S_DONE;
          end else begin
            cand_d  = cur_q;
            state_d = S_DECIDE;
          end
        end else begin
          if ((dm_rd_q.deadline < item_q.now_seconds) && (cand_q == ipft_pkg::NIL)) begin
            cand_d = cur_q;
          end
          last_d  = cur_q;
          cur_d   = cn_rd_q;
          state_d = S_LK_RD;
        end
      end
      S_DECIDE: begin
        if (ipft_pkg::LIM_W'(used_q) >= limit) begin
          res_d.tf = 1'b1;
          state_d  = S_DONE;
          if ({1'b0, item_q.now_seconds} >
              {1'b0, lastem_q} + {17'd0, cfg_i.emergency_period}) begin
            lastem_d = item_q.now_seconds;
            grace_d  = '0;
            ret_d    = S_DONE;
            state_d  = S_PR_CHK;
          end
        end else if (cand_q != ipft_pkg::NIL) begin
          ent_d   = cand_q;
          state_d = S_RU_RD;
        end else begin
          used_d = used_q + ipft_pkg::ptr_t'(1);
          if (sp_q != '0) begin
            ent_d = {1'b0, fs_rd_q};
            sp_d  = sp_q - ipft_pkg::ptr_t'(1);
          end else begin
            ent_d   = fresh_q;
            fresh_d = fresh_q + ipft_pkg::ptr_t'(1);
          end
          state_d = S_AL_A;
        end
      end
      S_RU_RD: state_d = S_RU_EV;
      S_RU_EV: begin
        // the newest entry stays where it is
        if (an_rd_q == ipft_pkg::NIL) begin
          state_d = S_WRITE;
        end else begin
          if (ap_rd_q != ipft_pkg::NIL) begin
            an_we = 1'b1; an_wa = ap_rd_q; an_wd = an_rd_q;
          end else begin
            head_d = an_rd_q;
          end
          ap_we = 1'b1; ap_wa = an_rd_q; ap_wd = ap_rd_q;
          state_d = S_RU_A;
        end
      end
      S_RU_A: begin
        an_we = 1'b1; an_wa = tail_q; an_wd = ent_q;
        ap_we = 1'b1; ap_wa = ent_q;  ap_wd = tail_q;
        state_d = S_RU_B;
      end
      S_RU_B: begin
        an_we = 1'b1; an_wa = ent_q; an_wd = ipft_pkg::NIL;
        tail_d  = ent_q;
        state_d = S_WRITE;
      end
      S_AL_A: begin
        cn_we = 1'b1; cn_wa = ent_q; cn_wd = ipft_pkg::NIL;
        cp_we = 1'b1; cp_wa = ent_q; cp_wd = last_q;
        an_we = 1'b1; an_wa = ent_q; an_wd = ipft_pkg::NIL;
        ap_we = 1'b1; ap_wa = ent_q; ap_wd = tail_q;
        state_d = S_AL_B;
      end
      S_AL_B: begin
        if (last_q != ipft_pkg::NIL) begin
          cn_we = 1'b1; cn_wa = last_q; cn_wd = ent_q;
        end else begin
          bh_we = 1'b1; bh_wd = ent_q;
        end
        if (tail_q != ipft_pkg::NIL) begin
          an_we = 1'b1; an_wa = tail_q; an_wd = ent_q;
        end else begin
          head_d = ent_q;
        end
        tail_d  = ent_q;
        state_d = S_WRITE;
      end
      S_WRITE: begin
        rec.frag_id   = item_q.frag_id;
        rec.protocol  = item_q.protocol;
        rec.src       = item_q.source_address;
        rec.dst       = item_q.dest_address;
        rec.deadline  = dl_sum[32] ? 32'hffff_ffff : dl_sum[31:0];
        rec.has_first = item_q.is_first;
        rec.header    = item_q.is_first ? item_q.header : '0;
        rec.bucket    = item_q.bucket;
        rec.packets   = '0;
        rec.bytes     = '0;
        if (!item_q.is_first && !cfg_i.external_sampling) begin
          rec.packets = 32'd1;
          rec.bytes   = {16'd0, item_q.packet_length};
        end
        dm_we = 1'b1; dm_wd = rec;
        res_d.hf  = item_q.is_first;
        res_d.hdr = item_q.is_first ? 64'(item_q.header) : 64'd0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dm_rd_q <= dm_mem[rd_idx[IW-1:0]];
    cn_rd_q <= cn_mem[rd_idx[IW-1:0]];
    cp_rd_q <= cp_mem[rd_idx[IW-1:0]];
    an_rd_q <= an_mem[rd_idx[IW-1:0]];
    ap_rd_q <= ap_mem[rd_idx[IW-1:0]];
    fs_rd_q <= fs_mem[fs_ra[IW-1:0]];
    bh_rd_q <= bh_mem[item_q.bucket];
    if (dm_we) dm_mem[dm_wa[IW-1:0]] <= dm_wd;
    if (cn_we) cn_mem[cn_wa[IW-1:0]] <= cn_wd;
    if (cp_we) cp_mem[cp_wa[IW-1:0]] <= cp_wd;
    if (an_we) an_mem[an_wa[IW-1:0]] <= an_wd;
    if (ap_we) ap_mem[ap_wa[IW-1:0]] <= ap_wd;
    if (fs_we) fs_mem[fs_wa[IW-1:0]] <= fs_wd;
    if (bh_we) bh_mem[bh_wa] <= bh_wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bh_vld_q    <= '0;
      bh_vld_rd_q <= 1'b0;
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      head_q      <= ipft_pkg::NIL;
      tail_q      <= ipft_pkg::NIL;
      used_q      <= '0;
      fresh_q     <= '0;
      sp_q        <= '0;
      nprune_q    <= {17'd0, ipft_pkg::RST_PRUNE_PERIOD};
      lastem_q    <= '0;
      ov_q        <= 1'b0;
    end else begin
      bh_vld_rd_q <= bh_vld_q[item_q.bucket];
      if (bh_we) bh_vld_q[bh_wa] <= 1'b1;
      state_q  <= state_d;
      ret_q    <= ret_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      used_q   <= used_d;
      fresh_q  <= fresh_d;
      sp_q     <= sp_d;
      nprune_q <= nprune_d;
      lastem_q <= lastem_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    cur_q   <= cur_d;
    cand_q  <= cand_d;
    last_q  <= last_d;
    ent_q   <= ent_d;
    grace_q <= grace_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

`ifndef NO_ASSERTIONS
  a_entry_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, fresh_q} == {1'b0, used_q} + {1'b0, sp_q})
    else $error("fresh, used and free stack counts disagree");
  a_age_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((head_q == ipft_pkg::NIL) == (used_q == '0)))
    else $error("age list emptiness disagrees with used count");
  a_age_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q == ipft_pkg::NIL) == (tail_q == ipft_pkg::NIL))
    else $error("age list head and tail disagree");
  a_full_no_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_q.tf) |-> (!res_q.hf && !res_q.sv))
    else $error("skipped fragment reports a header or sums");
`endif

endmodule

// ===== rtl/ipv4_fragment_tracker_top.sv =====
// IPv4 fragment tracker. Each word on in_i is one fragment; exactly one word comes out on out_o
// for it, in order. The front accepts a fragment, runs nine hash mix rows and then hands it,
// once there is room, to a two-deep queue, which lets the front take the next fragment while
// the table engine works on older fragments. The engine's work per fragment grows with each
// chain entry walked, with the reuse of an expired entry that is not the newest, and with each
// entry removed by a prune pass. A stalled output holds one result and then stalls the engine.
// Registers may be written only while no fragment is in flight. The table needs no clearing
// pass after reset.
module ipv4_fragment_tracker_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  frag_in_if.sink    in_i,
  frag_out_if.source out_o,
  cfg_if.sink        cfg_i
);

  ipft_pkg::cfg_t  cfg_q;
  ipft_pkg::item_t f_item, q_item;
  logic            f_valid, q_full, q_valid, q_pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entry_timeout     <= ipft_pkg::RST_ENTRY_TIMEOUT;
      cfg_q.prune_period      <= ipft_pkg::RST_PRUNE_PERIOD;
      cfg_q.prune_grace       <= ipft_pkg::RST_PRUNE_GRACE;
      cfg_q.emergency_period  <= ipft_pkg::RST_EMERGENCY_PERIOD;
      cfg_q.entry_limit       <= ipft_pkg::RST_ENTRY_LIMIT;
      cfg_q.hash_seed         <= ipft_pkg::RST_HASH_SEED;
      cfg_q.external_sampling <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        ipft_pkg::CFG_ENTRY_TIMEOUT:     cfg_q.entry_timeout     <= cfg_i.data[15:0];
        ipft_pkg::CFG_PRUNE_PERIOD:      cfg_q.prune_period      <= cfg_i.data[15:0];
        ipft_pkg::CFG_PRUNE_GRACE:       cfg_q.prune_grace       <= cfg_i.data[15:0];
        ipft_pkg::CFG_EMERGENCY_PERIOD:  cfg_q.emergency_period  <= cfg_i.data[15:0];
        ipft_pkg::CFG_ENTRY_LIMIT:       cfg_q.entry_limit       <= cfg_i.data[10:0];
        ipft_pkg::CFG_HASH_SEED:         cfg_q.hash_seed         <= cfg_i.data;
        ipft_pkg::CFG_EXTERNAL_SAMPLING: cfg_q.external_sampling <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  ipft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .seed_i       (cfg_q.hash_seed),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (!q_full)
  );

  ipft_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (f_valid && !q_full),
    .push_item_i (f_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  ipft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_o        (out_o)
  );

endmodule
